### rtl/core/assert_macros.svh
// Assertion macros for the RTL of the attention decode core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checks an implication at every rising clock edge outside reset.
`define CSAD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("csad assertion failed");
// Checks that a condition never holds outside reset.
`define CSAD_NEVER(lbl, clk, rst_n, cond) \
  `CSAD_ASSERT(lbl, clk, rst_n, !(cond))
`else
`define CSAD_ASSERT(lbl, clk, rst_n, prop)
`define CSAD_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

### rtl/core/csad_pkg.sv
// Package of constants, types and tables for the attention decode core.
package csad_pkg;

  localparam int HEAD_DIM   = 64;
  localparam int NUM_HEADS  = 8;
  localparam int MAX_TOKENS = 512;

  localparam int HEAD_W  = 3;
  localparam int ELEM_W  = 6;
  localparam int DATA_W  = 16;
  localparam int SCALE_W = 16;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd8192;

  localparam int POS_W       = $clog2(MAX_TOKENS + 1);
  localparam int PIDX_W      = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
  localparam int STORE_DEPTH = MAX_TOKENS * NUM_HEADS * HEAD_DIM;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);

  localparam int SCORE_W   = 32;
  localparam int ACC_W     = 43;
  localparam int DOT_MAG_W = 37;
  localparam int WGT_W     = 17;
  localparam int SUM_W     = WGT_W + PIDX_W;
  localparam int NUM_W     = ACC_W;
  localparam int DIV_CW    = $clog2(NUM_W + 1);
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 32;

  typedef enum logic [4:0] {
    ST_IDLE, ST_FULL_OUT,
    ST_SC_INIT, ST_SC_RUN, ST_SC_WAIT, ST_SC_ABS, ST_SC_LO, ST_SC_HI, ST_SC_WR,
    ST_W_RD, ST_W_T, ST_W_I, ST_W_WR,
    ST_V_INIT, ST_V_RUN, ST_V_WAIT, ST_V_DIV, ST_V_DWAIT, ST_V_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic in_ready;
    logic comp_init;
    logic acc_clr;
    logic d_clr;
    logic d_inc;
    logic p_clr;
    logic p_inc;
    logic mac_issue;
    logic mac_last;
    logic mode_val;
    logic sc_abs;
    logic sc_lo;
    logic sc_hi;
    logic sc_wr;
    logic w_t;
    logic w_i;
    logic w_wr;
    logic div_start;
    logic out_load;
    logic out_full;
    logic pos_adv;
  } ctrl_cmd_t;

  typedef struct packed {
    logic start_compute;
    logic start_full;
    logic d_last;
    logic p_last;
    logic mac_done;
    logic div_done;
    logic div_busy;
    logic out_busy;
  } ctrl_st_t;

  // 2^(-k/16) in Q1.16 for k = 0..16.
  function automatic logic [16:0] pow2_tab(input logic [4:0] k);
    logic [16:0] v;
    case (k)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62758;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37315;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/csad_div.sv
// Restoring divider, one quotient bit per cycle.
module csad_div
  import csad_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [SUM_W-1:0] den_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  logic [DIV_CW-1:0] cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [SUM_W-1:0]  rem_q, rem_d;
  logic [NUM_W-1:0]  quo_q, quo_d;
  logic [SUM_W-1:0]  den_q, den_d;
  logic [SUM_W:0]    shifted;
  logic              fits;

  always_comb begin
    shifted = {rem_q, quo_q[NUM_W-1]};
    fits    = shifted >= {1'b0, den_q};
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    rem_d   = rem_q;
    quo_d   = quo_q;
    den_d   = den_q;
    if (start_i) begin
      cnt_d = DIV_CW'(NUM_W);
      rem_d = '0;
      quo_d = num_i;
      den_d = den_i;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == DIV_CW'(1));
      rem_d  = fits ? SUM_W'(shifted - {1'b0, den_q}) : shifted[SUM_W-1:0];
      quo_d  = {quo_q[NUM_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign busy_o = cnt_q != '0;
  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

### rtl/core/csad_datapath.sv
// Datapath: key/value cache, buffers, shared multiply-accumulate, softmax and output register.
module csad_datapath
  import csad_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic [0:0]             s_axis_tuser,
  input  logic                   s_axis_tlast,
  input  logic                   cfg_valid_i,
  input  logic [SCALE_W-1:0]     cfg_data_i,
  input  ctrl_cmd_t              cmd_i,
  output ctrl_st_t               st_o,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic [0:0]             m_axis_tuser,
  output logic                   m_axis_tlast
);

  function automatic logic [STORE_AW-1:0] cell_addr(input logic [PIDX_W-1:0] pos,
                                                    input logic [HEAD_W-1:0] head,
                                                    input logic [ELEM_W-1:0] elem);
    return STORE_AW'(pos) * STORE_AW'(NUM_HEADS * HEAD_DIM)
         + STORE_AW'(head) * STORE_AW'(HEAD_DIM) + STORE_AW'(elem);
  endfunction

  // Input unpacking.
  logic [HEAD_W-1:0]        in_head;
  logic [ELEM_W-1:0]        in_elem;
  logic signed [DATA_W-1:0] in_q, in_k, in_v;
  logic                     is_clr, in_ok, full, accept, store_en, last_elem;

  assign in_head   = s_axis_tdata[2:0];
  assign in_elem   = s_axis_tdata[8:3];
  assign in_q      = s_axis_tdata[24:9];
  assign in_k      = s_axis_tdata[40:25];
  assign in_v      = s_axis_tdata[56:41];
  assign is_clr    = s_axis_tuser[0];
  assign in_ok     = (32'(in_head) < NUM_HEADS) && (32'(in_elem) < HEAD_DIM);
  assign last_elem = in_elem == ELEM_W'(HEAD_DIM - 1);
  assign accept    = s_axis_tvalid && cmd_i.in_ready;
  assign store_en  = accept && !is_clr && in_ok && !full;

  // Position, latched item fields and configuration.
  logic [POS_W-1:0]   pos_q;
  logic [HEAD_W-1:0]  head_q;
  logic               tl_q;
  logic [SCALE_W-1:0] scale_q;

  assign full = pos_q == POS_W'(MAX_TOKENS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      scale_q <= SCALE_RESET;
    end else begin
      if (cfg_valid_i) scale_q <= cfg_data_i;
      if (accept && is_clr) begin
        pos_q <= '0;
      end else if (accept && s_axis_tlast && !st_o.start_compute && !full) begin
        pos_q <= pos_q + 1'b1;
      end else if (cmd_i.pos_adv && tl_q && !full) begin
        pos_q <= pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      head_q <= in_head;
      tl_q   <= s_axis_tlast;
    end
  end

  // Counters.
  logic [ELEM_W-1:0] d_q;
  logic [PIDX_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.d_clr)      d_q <= '0;
    else if (cmd_i.d_inc) d_q <= d_q + 1'b1;
    if (cmd_i.p_clr || cmd_i.comp_init) p_q <= '0;
    else if (cmd_i.p_inc)               p_q <= p_q + 1'b1;
  end

  // Memories.
  logic signed [DATA_W-1:0]  kmem [STORE_DEPTH];
  logic signed [DATA_W-1:0]  vmem [STORE_DEPTH];
  logic signed [DATA_W-1:0]  qmem [HEAD_DIM];
  logic signed [SCORE_W-1:0] smem [MAX_TOKENS];
  logic signed [DATA_W-1:0]  kd_q, vd_q, qd_q;
  logic signed [SCORE_W-1:0] sd_q;
  logic [STORE_AW-1:0]       wr_addr, rd_addr;
  logic signed [SCORE_W-1:0] score_d;
  logic [WGT_W-1:0]          wgt_d;

  assign wr_addr = cell_addr(pos_q[PIDX_W-1:0], in_head, in_elem);
  assign rd_addr = cell_addr(p_q, head_q, d_q);

  always_ff @(posedge clk_i) begin
    if (store_en) begin
      kmem[wr_addr] <= in_k;
      vmem[wr_addr] <= in_v;
      qmem[in_elem] <= in_q;
    end
    kd_q <= kmem[rd_addr];
    vd_q <= vmem[rd_addr];
    qd_q <= qmem[d_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sc_wr)     smem[p_q] <= score_d;
    else if (cmd_i.w_wr) smem[p_q] <= SCORE_W'(wgt_d);
    sd_q <= smem[p_q];
  end

  // Shared multiply-accumulate pipeline: read, multiply, accumulate.
  logic                     v0_q, l0_q, m0_q, v1_q, l1_q, done_q;
  logic signed [17:0]       mac_a;
  logic signed [DATA_W-1:0] mac_b;
  logic signed [33:0]       prod_d, prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic [ACC_W-1:0]         acc_mag;

  assign mac_a  = m0_q ? $signed({1'b0, sd_q[WGT_W-1:0]}) : 18'(qd_q);
  assign mac_b  = m0_q ? vd_q : kd_q;
  assign prod_d = mac_a * mac_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q   <= 1'b0;
      l0_q   <= 1'b0;
      m0_q   <= 1'b0;
      v1_q   <= 1'b0;
      l1_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v0_q   <= cmd_i.mac_issue;
      l0_q   <= cmd_i.mac_issue && cmd_i.mac_last;
      m0_q   <= cmd_i.mode_val;
      v1_q   <= v0_q;
      l1_q   <= l0_q;
      done_q <= v1_q && l1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (cmd_i.acc_clr) acc_q <= '0;
    else if (v1_q)     acc_q <= acc_q + ACC_W'(prod_q);
  end

  assign acc_mag = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);

  // Score scaling over partial products, running maximum.
  logic [DOT_MAG_W-1:0]      dmag_q;
  logic                      ssgn_q;
  logic [34:0]               pplo_q;
  logic [33:0]               pphi_q;
  logic [53:0]               sprod;
  logic [25:0]               rr;
  logic signed [SCORE_W-1:0] mx_q;

  assign sprod   = {pphi_q, 19'b0} + 54'(pplo_q) + 54'(1 << 27);
  assign rr      = sprod[53:28];
  assign score_d = ssgn_q ? -SCORE_W'(rr) : SCORE_W'(rr);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sc_abs) begin
      dmag_q <= acc_mag[DOT_MAG_W-1:0];
      ssgn_q <= acc_q[ACC_W-1];
    end
    if (cmd_i.sc_lo) pplo_q <= dmag_q[18:0] * scale_q;
    if (cmd_i.sc_hi) pphi_q <= dmag_q[DOT_MAG_W-1:19] * scale_q;
    if (cmd_i.comp_init)                     mx_q <= {1'b1, {(SCORE_W-1){1'b0}}};
    else if (cmd_i.sc_wr && score_d > mx_q) mx_q <= score_d;
  end

  // Softmax weights: base-2 exponent, table interpolation, shift.
  logic [SCORE_W:0]   diff;
  logic [42:0]        tprod;
  logic [26:0]        t_q;
  logic [16:0]        tk, tk1, tk_q;
  logic [24:0]        dp_q;
  logic               big_q;
  logic [4:0]         sh_q;
  logic [16:0]        interp;
  logic [SUM_W-1:0]   sum_q;

  assign diff   = {mx_q[SCORE_W-1], mx_q} - {sd_q[SCORE_W-1], sd_q};
  assign tprod  = diff[25:0] * LOG2E_Q16;
  assign tk     = pow2_tab({1'b0, t_q[11:8]});
  assign tk1    = pow2_tab({1'b0, t_q[11:8]} + 5'd1);
  assign interp = tk_q - dp_q[24:8];
  assign wgt_d  = big_q ? '0 : (interp >> sh_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.w_t) t_q <= tprod[42:16];
    if (cmd_i.w_i) begin
      tk_q  <= tk;
      dp_q  <= (tk - tk1) * t_q[7:0];
      big_q <= t_q[26:12] >= 15'd32;
      sh_q  <= t_q[16:12];
    end
    if (cmd_i.comp_init)  sum_q <= '0;
    else if (cmd_i.w_wr)  sum_q <= sum_q + SUM_W'(wgt_d);
  end

  // Normalizing division.
  logic             vsgn_q, div_busy, div_done;
  logic [NUM_W-1:0] quot;
  logic [NUM_W-1:0] qc;
  logic signed [DATA_W-1:0] res;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) vsgn_q <= acc_q[ACC_W-1];
  end

  csad_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (acc_mag + NUM_W'(sum_q >> 1)),
    .den_i   (sum_q),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  always_comb begin
    qc = (quot > NUM_W'(32768)) ? NUM_W'(32768) : quot;
    if (vsgn_q)                   res = DATA_W'(-qc);
    else if (qc == NUM_W'(32768)) res = 16'sd32767;
    else                          res = DATA_W'(qc);
  end

  // Output register.
  logic                     ov_q;
  logic [HEAD_W-1:0]        oh_q;
  logic [ELEM_W-1:0]        oe_q;
  logic signed [DATA_W-1:0] oval_q;
  logic                     ol_q, of_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      ov_q <= 1'b1;
    end else if (m_axis_tready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (cmd_i.out_full) begin
        oh_q   <= head_q;
        oe_q   <= '0;
        oval_q <= '0;
        ol_q   <= 1'b1;
        of_q   <= 1'b1;
      end else begin
        oh_q   <= head_q;
        oe_q   <= d_q;
        oval_q <= res;
        ol_q   <= d_q == ELEM_W'(HEAD_DIM - 1);
        of_q   <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {7'b0, oval_q, oe_q, oh_q};
  assign m_axis_tuser  = of_q;
  assign m_axis_tlast  = ol_q;

  assign st_o.start_compute = !is_clr && in_ok && !full && last_elem;
  assign st_o.start_full    = !is_clr && in_ok && full && last_elem;
  assign st_o.d_last        = d_q == ELEM_W'(HEAD_DIM - 1);
  assign st_o.p_last        = POS_W'(p_q) == pos_q;
  assign st_o.mac_done      = done_q;
  assign st_o.div_done      = div_done;
  assign st_o.div_busy      = div_busy;
  assign st_o.out_busy      = ov_q;

endmodule

### rtl/core/csad_ctrl.sv
// Controller state machine sequencing scoring, softmax and the weighted value sum.
module csad_ctrl
  import csad_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  ctrl_st_t  st_i,
  output ctrl_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (in_valid_i && st_i.start_compute) begin
          cmd_o.comp_init = 1'b1;
          state_d = ST_SC_INIT;
        end else if (in_valid_i && st_i.start_full) begin
          state_d = ST_FULL_OUT;
        end
      end
      ST_FULL_OUT: begin
        if (!st_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_full = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_SC_INIT: begin
        cmd_o.acc_clr = 1'b1;
        cmd_o.d_clr   = 1'b1;
        state_d = ST_SC_RUN;
      end
      ST_SC_RUN: begin
        cmd_o.mac_issue = 1'b1;
        if (st_i.d_last) begin
          cmd_o.mac_last = 1'b1;
          state_d = ST_SC_WAIT;
        end else begin
          cmd_o.d_inc = 1'b1;
        end
      end
      ST_SC_WAIT: if (st_i.mac_done) state_d = ST_SC_ABS;
      ST_SC_ABS: begin
        cmd_o.sc_abs = 1'b1;
        state_d = ST_SC_LO;
      end
      ST_SC_LO: begin
        cmd_o.sc_lo = 1'b1;
        state_d = ST_SC_HI;
      end
      ST_SC_HI: begin
        cmd_o.sc_hi = 1'b1;
        state_d = ST_SC_WR;
      end
      ST_SC_WR: begin
        cmd_o.sc_wr = 1'b1;
        if (st_i.p_last) begin
          cmd_o.p_clr = 1'b1;
          state_d = ST_W_RD;
        end else begin
          cmd_o.p_inc = 1'b1;
          state_d = ST_SC_INIT;
        end
      end
      ST_W_RD: state_d = ST_W_T;
      ST_W_T: begin
        cmd_o.w_t = 1'b1;
        state_d = ST_W_I;
      end
      ST_W_I: begin
        cmd_o.w_i = 1'b1;
        state_d = ST_W_WR;
      end
      ST_W_WR: begin
        cmd_o.w_wr = 1'b1;
        if (st_i.p_last) begin
          cmd_o.d_clr = 1'b1;
          state_d = ST_V_INIT;
        end else begin
          cmd_o.p_inc = 1'b1;
          state_d = ST_W_RD;
        end
      end
      ST_V_INIT: begin
        cmd_o.acc_clr = 1'b1;
        cmd_o.p_clr   = 1'b1;
        state_d = ST_V_RUN;
      end
      ST_V_RUN: begin
        cmd_o.mac_issue = 1'b1;
        cmd_o.mode_val  = 1'b1;
        if (st_i.p_last) begin
          cmd_o.mac_last = 1'b1;
          state_d = ST_V_WAIT;
        end else begin
          cmd_o.p_inc = 1'b1;
        end
      end
      ST_V_WAIT: if (st_i.mac_done) state_d = ST_V_DIV;
      ST_V_DIV: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_V_DWAIT;
      end
      ST_V_DWAIT: if (st_i.div_done) state_d = ST_V_OUT;
      ST_V_OUT: begin
        if (!st_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          if (st_i.d_last) begin
            cmd_o.pos_adv = 1'b1;
            state_d = ST_IDLE;
          end else begin
            cmd_o.d_inc = 1'b1;
            state_d = ST_V_INIT;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

### rtl/core/cached_self_attention_decode_core.sv
// Top level of the cached self-attention decode core.
//
//   Channel   Direction  Transaction
//   s_axis    in         one query/key/value element of one head, or a cache clear
//   m_axis    out        one element of a head's attention output, or a cache-full flag
//   cfg       in         write of the score scale register
//
// An element transaction that does not complete a head is accepted while the core is
// idle; its key and value go straight into the cache row of the current position,
// unless the cache is full. The transaction carrying a head's last element starts the
// computation over the position+1 cached rows: scoring runs on the single shared
// multiply-accumulate unit, then softmax weighting, and each output element comes from
// the same unit and the bit-serial divider. The input is not ready while a head is
// being computed. The output register holds a result while m_axis stalls; the input is
// ready again once the last result is loaded. Reset clears the position and control
// state and sets the scale register to its reset value; cache contents are not cleared,
// and the user must write rows before they are read, which the core does not enforce.
module cached_self_attention_decode_core
  import csad_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Input stream. tdata fields from bit 0 up: head_index[3], elem_index[6],
  // query_value[16], key_value[16], value_value[16], zero fill.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser fields: op[1] (clear when set).
  input  logic [0:0]             s_axis_tuser,
  input  logic                   s_axis_tlast,
  // Output stream. tdata fields from bit 0 up: out_head[3], out_elem[6],
  // out_value[16], zero fill.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // tuser fields: cache_full[1].
  output logic [0:0]             m_axis_tuser,
  output logic                   m_axis_tlast,
  // Score scale register write.
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [SCALE_W-1:0]     cfg_data_i
);

`include "assert_macros.svh"

  ctrl_cmd_t cmd;
  ctrl_st_t  st;

  // Always writable; the user must write only while the core is idle, unchecked here.
  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = cmd.in_ready;

  csad_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  csad_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd),
    .st_o          (st),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // A result is only loaded into an empty output register.
  `CSAD_NEVER(a_load_empty, clk_i, rst_ni, cmd.out_load && m_axis_tvalid)
  // The divider is never restarted while it is still working.
  `CSAD_NEVER(a_div_free, clk_i, rst_ni, cmd.div_start && st.div_busy)
  // A head-completing transaction blocks the input on the next cycle.
  `CSAD_ASSERT(a_busy_after_start, clk_i, rst_ni,
               (s_axis_tvalid && s_axis_tready && st.start_compute) |=> !s_axis_tready)

endmodule

### test/tb_cached_self_attention_decode_core.sv
// Self-checking testbench for the cached self-attention decode core.
module tb_cached_self_attention_decode_core;
  import csad_pkg::*;

  localparam int CLK_HALF     = 2;
  localparam int IDLE_PCT     = 26;
  localparam int STALL_LIMIT  = 50000;
  localparam int HOLD_CYCLES  = 2000;
  localparam int SETTLE       = 60;

  typedef struct packed {
    logic [HEAD_W-1:0] head;
    logic [ELEM_W-1:0] elem;
    logic [DATA_W-1:0] value;
    logic              last;
    logic              full;
  } attn_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic [0:0] s_axis_tuser = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;
  logic m_axis_tlast;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [SCALE_W-1:0] cfg_data_i = '0;

  cached_self_attention_decode_core dut (.*);

  initial forever #CLK_HALF clk_i = ~clk_i;

  // Golden state of the block.
  logic [SCALE_W-1:0]      scale_reg;
  logic signed [15:0]      key_mem [int];
  logic signed [15:0]      val_mem [int];
  logic signed [15:0]      query_row [HEAD_DIM];
  int unsigned             position;
  attn_result_t            pending_results [$];

  int  error_count;
  int  items_sent;
  int  results_seen;
  int  heads_done;
  bit  steady;       // no idling on either side while set
  bit  hold_request; // asks the output side for one long stall

  const int unsigned POW2_TAB [17] = '{65536, 62758, 60097, 57549, 55109, 52773, 50535,
    48393, 46341, 44376, 42495, 40693, 38968, 37315, 35734, 34219, 32768};

  function automatic int slot(int unsigned pos, int unsigned head, int unsigned elem);
    return (pos * NUM_HEADS + head) * HEAD_DIM + elem;
  endfunction

  function automatic longint read_mem(ref logic signed [15:0] mem [int], input int idx);
    return mem.exists(idx) ? longint'(mem[idx]) : 64'sd0;
  endfunction

  function automatic longint unsigned exp2_weight(longint unsigned t);
    longint unsigned ip;
    int unsigned k, r, w;
    ip = t >> 12;
    k  = 32'((t >> 8) & 15);
    r  = 32'(t & 255);
    if (ip >= 32) return 0;
    w = POW2_TAB[k] - (((POW2_TAB[k] - POW2_TAB[k+1]) * r) >> 8);
    return longint'(w >> ip);
  endfunction

  function automatic void clear_cache();
    key_mem.delete();
    val_mem.delete();
    foreach (query_row[i]) query_row[i] = '0;
    position = 0;
  endfunction

  // Works out the results caused by one accepted item and queues them.
  function automatic void attend(logic op, logic [2:0] head, logic [5:0] elem,
                                 logic [15:0] q, logic [15:0] k, logic [15:0] v,
                                 logic tok_last);
    longint scores [MAX_TOKENS];
    longint unsigned weights [MAX_TOKENS];
    longint dot, prod, mx, acc, res;
    longint unsigned mag, sum, quo;
    int unsigned len;
    attn_result_t r;
    if (op) begin
      clear_cache();
      return;
    end
    if (position >= MAX_TOKENS) begin
      if (elem == HEAD_DIM - 1) begin
        r = '{head: head, elem: '0, value: '0, last: 1'b1, full: 1'b1};
        pending_results.push_back(r);
      end
    end else begin
      query_row[elem] = q;
      key_mem[slot(position, head, elem)] = k;
      val_mem[slot(position, head, elem)] = v;
      if (elem == HEAD_DIM - 1) begin
        len = position + 1;
        mx = -(64'sd1 << 40);
        for (int p = 0; p < len; p++) begin
          dot = 0;
          for (int d = 0; d < HEAD_DIM; d++)
            dot += longint'(query_row[d]) * read_mem(key_mem, slot(p, head, d));
          prod = dot * longint'({1'b0, scale_reg});
          mag = (prod < 0) ? -prod : prod;
          mag = (mag + (64'd1 << 27)) >> 28;
          scores[p] = (prod < 0) ? -longint'(mag) : longint'(mag);
          if (scores[p] > mx) mx = scores[p];
        end
        sum = 0;
        for (int p = 0; p < len; p++) begin
          weights[p] = exp2_weight((longint'(mx - scores[p]) * 94548) >> 16);
          sum += weights[p];
        end
        if (sum == 0) sum = 1;
        for (int d = 0; d < HEAD_DIM; d++) begin
          acc = 0;
          for (int p = 0; p < len; p++)
            acc += longint'(weights[p]) * read_mem(val_mem, slot(p, head, d));
          mag = (acc < 0) ? -acc : acc;
          quo = (mag + sum / 2) / sum;
          if (quo > 32768) quo = 32768;
          res = (acc < 0) ? -longint'(quo) : longint'(quo);
          if (res > 32767) res = 32767;
          r = '{head: head, elem: d[5:0], value: res[15:0], last: (d == HEAD_DIM - 1),
                full: 1'b0};
          pending_results.push_back(r);
        end
      end
    end
    if (tok_last && position < MAX_TOKENS) position++;
  endfunction

  // Offers one item and waits for its transaction; tvalid is lowered only when a gap
  // is taken, so back-to-back items stay valid.
  task automatic send_item(logic op, logic [2:0] head, logic [5:0] elem,
                           logic [15:0] q, logic [15:0] k, logic [15:0] v, logic tok_last);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, v, k, q, elem, head};
    s_axis_tuser  <= op;
    s_axis_tlast  <= tok_last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    attend(op, head, elem, q, k, v, tok_last);
    items_sent++;
  endtask

  // Lowers the input, waits for all expected results and lets the block settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_scale(logic [SCALE_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    scale_reg = value;
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2, 3: return 16'($signed($urandom_range(8191)) - 4096);
      default: return 16'($urandom);
    endcase
  endfunction

  // Sends all elements of one head: the first 63 in shuffled order, then the one
  // that completes the head. tok_last marks the end of the token.
  task automatic send_head(logic [2:0] head, bit tok_last, bit extremes = 0);
    int order [HEAD_DIM-1];
    int j, tmp;
    logic [15:0] q, k, v;
    foreach (order[i]) order[i] = i;
    for (int i = HEAD_DIM - 2; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = order[i]; order[i] = order[j]; order[j] = tmp;
    end
    for (int i = 0; i < HEAD_DIM; i++) begin
      if (extremes) begin
        q = i[0] ? 16'h8000 : 16'h7FFF;
        k = i[1] ? 16'h8000 : 16'h7FFF;
        v = i[0] ? 16'h7FFF : 16'h8000;
      end else begin
        q = pick_sample(); k = pick_sample(); v = pick_sample();
      end
      send_item(1'b0, head, (i == HEAD_DIM - 1) ? 6'(HEAD_DIM - 1) : 6'(order[i]),
                q, k, v, tok_last && (i == HEAD_DIM - 1));
    end
    heads_done++;
  endtask

  task automatic send_clear();
    send_item(1'b1, 3'($urandom), 6'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 1'($urandom));
  endtask

  // Output side: random stalls, plus one long hold-off counted here on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_request = 1'b0;
      end
      m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Compares each output transaction with the oldest expected result.
  always @(posedge clk_i) begin
    attn_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("output transaction with no result expected: tdata %h", m_axis_tdata);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[2:0] !== want.head) begin
          $error("out_head: expected %0d, got %0d", want.head, m_axis_tdata[2:0]);
          error_count++;
        end
        if (m_axis_tdata[8:3] !== want.elem) begin
          $error("out_elem: expected %0d, got %0d", want.elem, m_axis_tdata[8:3]);
          error_count++;
        end
        if (m_axis_tdata[24:9] !== want.value) begin
          $error("out_value: expected %0d, got %0d", $signed(want.value),
                 $signed(m_axis_tdata[24:9]));
          error_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("out_last: expected %0b, got %0b", want.last, m_axis_tlast);
          error_count++;
        end
        if (m_axis_tuser[0] !== want.full) begin
          $error("cache_full: expected %0b, got %0b", want.full, m_axis_tuser[0]);
          error_count++;
        end
      end
    end
  end

  // Ends the run when no transaction of any kind completes for too long.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("cached_self_attention_decode_core regression: fail");
        $finish;
      end
    end
  end

  // One token of a head at the reset scale, with full-scale samples, sent back to
  // back; the output is held ready only while the items are sent.
  task automatic test_reset_scale();
    steady = 1'b1;
    send_head(3'd7, 1'b1, 1'b1);
    steady = 1'b0;
    drain();
  endtask

  // At full scale a second token is scored; the output side then stalls for a long
  // time while more input keeps coming, so the block fills and holds off its input.
  // A token end on an element that completes no head moves the position, then a
  // clear resets it; afterwards the input waits for all results.
  task automatic test_backpressure();
    write_scale(16'hFFFF);
    send_head(3'd7, 1'b1);
    hold_request = 1'b1;
    for (int i = 0; i < 4; i++)
      send_item(1'b0, 3'd7, 6'(i), pick_sample(), pick_sample(), pick_sample(), i == 3);
    send_clear();
    drain();
  endtask

  initial begin
    error_count = 0; items_sent = 0; results_seen = 0;
    heads_done = 0; steady = 1'b0; hold_request = 1'b0;
    scale_reg = SCALE_RESET;
    clear_cache();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_scale();
    test_backpressure();
    drain();
    $display("Covered %0d input items, %0d completed heads and %0d results,",
             items_sent, heads_done, results_seen);
    $display("at the reset and full score scales, with back-to-back input, a clear "
             + "and a long output stall.");
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("cached_self_attention_decode_core regression: pass");
    end else begin
      $display("cached_self_attention_decode_core regression: fail");
    end
    $finish;
  end

endmodule
